// ===== hdl/history_indexed_branch_target_buffer_assert.svh =====
// assertion macros for the history-indexed branch target buffer
`ifndef HISTORY_INDEXED_BRANCH_TARGET_BUFFER_ASSERT_SVH
`define HISTORY_INDEXED_BRANCH_TARGET_BUFFER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HIBTB_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define HIBTB_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== hdl/hibtb_pkg.sv =====
// shared sizes, types and helpers of the history-indexed branch target buffer
package hibtb_pkg;

   localparam int SETS          = 128;
   localparam int WAYS          = 4;
   localparam int HISTORY_BITS  = 7;
   localparam int TAG_BITS      = 32;
   localparam int ADDR_BITS     = 64;
   localparam int LEN_BITS      = 4;
   localparam int SET_BITS      = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_BITS      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int REQ_DATA_RAW  = 2 * ADDR_BITS + 1 + LEN_BITS;
   localparam int REQ_DATA_BITS = ((REQ_DATA_RAW + 7) / 8) * 8;
   localparam int RSP_DATA_RAW  = 1 + ADDR_BITS + 1;
   localparam int RSP_DATA_BITS = ((RSP_DATA_RAW + 7) / 8) * 8;

   localparam logic KIND_OTHER    = 1'b0;
   localparam logic KIND_INDIRECT = 1'b1;

   // one set: valid bits, recency ranks (0 = most recent), tags and targets
   typedef struct packed {
      logic [WAYS-1:0]                valid;
      logic [WAYS-1:0][WAY_BITS-1:0]  age;
      logic [WAYS-1:0][TAG_BITS-1:0]  tag;
      logic [WAYS-1:0][ADDR_BITS-1:0] target;
   } row_type;

   typedef struct packed {
      logic                en;
      logic [SET_BITS-1:0] addr;
   } wr_req_type;

   typedef struct packed {
      logic                 hit;
      logic [ADDR_BITS-1:0] pred;
      logic                 correct;
   } lookup_type;

   // contents of a set after reset: nothing valid, way w has rank w
   function automatic row_type reset_row();
      row_type r;
      r = '0;
      for (int w = 0; w < WAYS; w++) begin
         r.age[w] = WAY_BITS'(w);
      end
      return r;
   endfunction

endpackage

// ===== hdl/history_indexed_branch_target_buffer.sv =====
// top level of the history-indexed branch target buffer
//
// channel   dir  handshake              contents
// req_*     in   req_tvalid/req_tready  tuser: kind; tdata: pc, actual_target, taken, length
// rsp_*     out  rsp_tvalid/rsp_tready  tdata: hit, predicted_target, correct
//
// one item per cycle sustained while results are taken; an indirect lookup reads its set
// at the accepting edge, updates it and registers its result as it leaves the update stage
// the set memory has a single read and a single write port; a write to the set
// being read on the same edge is bypassed into the read data
// after reset a clearing sweep walks all 128 sets, one per cycle, with req_tready low
// a stalled result holds the update stage, which in turn holds req_tready low
`include "history_indexed_branch_target_buffer_assert.svh"

module history_indexed_branch_target_buffer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // kind
   input  logic                                req_tuser,
   // pc[63:0], actual_target[127:64], taken[128], length[132:129], zero fill
   input  logic [hibtb_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hit[0], predicted_target[64:1], correct[65], zero fill
   output logic [hibtb_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   // request fields
   logic [hibtb_pkg::ADDR_BITS-1:0] req_pc;
   logic [hibtb_pkg::ADDR_BITS-1:0] req_actual;
   logic                            req_taken;
   logic [hibtb_pkg::LEN_BITS-1:0]  req_length;
   logic [hibtb_pkg::SET_BITS-1:0]  req_set;

   logic accept;
   logic lookup_accept;
   logic adv;
   logic busy;

   // global taken history
   logic [hibtb_pkg::HISTORY_BITS-1:0] hist_ff, hist_in;

   // update stage
   logic                            s1_valid_ff, s1_valid_in;
   logic [hibtb_pkg::SET_BITS-1:0]  set_ff;
   logic [hibtb_pkg::TAG_BITS-1:0]  tag_ff;
   logic [hibtb_pkg::ADDR_BITS-1:0] fall_ff;
   logic [hibtb_pkg::ADDR_BITS-1:0] actual_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   hibtb_pkg::lookup_type rsp_ff;

   hibtb_pkg::row_type    rd_row;
   hibtb_pkg::row_type    new_row;
   hibtb_pkg::lookup_type lookup;
   hibtb_pkg::wr_req_type wr_req;

   // unpack, lowest field first
   assign req_pc     = req_tdata[hibtb_pkg::ADDR_BITS-1:0];
   assign req_actual = req_tdata[2*hibtb_pkg::ADDR_BITS-1:hibtb_pkg::ADDR_BITS];
   assign req_taken  = req_tdata[2*hibtb_pkg::ADDR_BITS];
   assign req_length = req_tdata[2*hibtb_pkg::ADDR_BITS+hibtb_pkg::LEN_BITS:
                                 2*hibtb_pkg::ADDR_BITS+1];

   // set index: low pc bits xor history
   assign req_set = req_pc[hibtb_pkg::SET_BITS-1:0] ^ hibtb_pkg::SET_BITS'(hist_ff);

   // update stage may move when empty or when its result has somewhere to go
   assign adv           = !s1_valid_ff || !rsp_valid_ff || rsp_tready;
   assign req_tready    = !busy && adv;
   assign accept        = req_tvalid && req_tready;
   assign lookup_accept = accept && (req_tuser == hibtb_pkg::KIND_INDIRECT);

   // every transfer shifts its taken bit in, lookups and others alike
   assign hist_in = accept ? hibtb_pkg::HISTORY_BITS'({hist_ff, req_taken}) : hist_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (lookup_accept) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_valid_ff && adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // write back the updated set as its result leaves the stage
   always_comb begin
      wr_req.en   = s1_valid_ff && adv;
      wr_req.addr = set_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hist_ff      <= hist_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lookup_accept) begin
         set_ff    <= req_set;
         tag_ff    <= req_pc[hibtb_pkg::TAG_BITS-1:0];
         fall_ff   <= req_pc + hibtb_pkg::ADDR_BITS'(req_length);
         actual_ff <= req_actual;
      end
      if (s1_valid_ff && adv) begin
         rsp_ff <= lookup;
      end
   end

   hibtb_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (lookup_accept),
      .rd_addr (req_set),
      .wr_req  (wr_req),
      .wr_row  (new_row),
      .rd_row  (rd_row),
      .busy    (busy)
   );

   hibtb_way_logic u_way_logic (
      .row     (rd_row),
      .tag     (tag_ff),
      .fall    (fall_ff),
      .actual  (actual_ff),
      .lookup  (lookup),
      .new_row (new_row)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = hibtb_pkg::RSP_DATA_BITS'({rsp_ff.correct, rsp_ff.pred, rsp_ff.hit});

   // no transfer while the sweep owns the memory
   `HIBTB_ASSERT_NOW(a_no_accept_in_sweep, clock, reset, busy, !req_tready,
      "request transfer during clearing sweep")

   // a stalled lookup keeps its set and stays in the stage
   `HIBTB_ASSERT_NEXT(a_stall_holds_stage, clock, reset, s1_valid_ff && !adv,
      s1_valid_ff && $stable(set_ff) && $stable(tag_ff),
      "update stage changed while stalled")

   // a lookup leaving the stage shows up as a result
   `HIBTB_ASSERT_NEXT(a_lookup_gives_result, clock, reset, s1_valid_ff && adv,
      rsp_valid_ff && rsp_ff.hit == $past(lookup.hit),
      "lookup left the stage without a result")

   // a written-back set keeps every valid way and holds at least the touched one
   `HIBTB_ASSERT_NOW(a_writeback_has_valid, clock, reset, wr_req.en,
      (new_row.valid != '0) && ($countones(new_row.valid) >= $countones(rd_row.valid)),
      "write-back lost a valid way")

endmodule

// ===== hdl/hibtb_store.sv =====
// set memory with post-reset clearing sweep and write-to-read bypass
module hibtb_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [hibtb_pkg::SET_BITS-1:0] rd_addr,
   input  hibtb_pkg::wr_req_type        wr_req,
   input  hibtb_pkg::row_type           wr_row,
   output hibtb_pkg::row_type           rd_row,
   output logic                         busy
);

   hibtb_pkg::row_type             row_mem [hibtb_pkg::SETS];
   hibtb_pkg::row_type             rd_row_ff;
   logic                           busy_ff, busy_in;
   logic [hibtb_pkg::SET_BITS-1:0] clr_addr_ff, clr_addr_in;

   logic                           we;
   logic [hibtb_pkg::SET_BITS-1:0] waddr;
   hibtb_pkg::row_type             wdata;

   // sweep owns the write port until every set is cleared
   always_comb begin
      we    = busy_ff ? 1'b1 : wr_req.en;
      waddr = busy_ff ? clr_addr_ff : wr_req.addr;
      wdata = busy_ff ? hibtb_pkg::reset_row() : wr_row;
   end

   always_comb begin
      clr_addr_in = clr_addr_ff;
      busy_in     = busy_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == hibtb_pkg::SET_BITS'(hibtb_pkg::SETS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // read data registered; a same-edge write to the read set is passed through
   always_ff @(posedge clock) begin
      if (we) begin
         row_mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_row_ff <= (we && waddr == rd_addr) ? wdata : row_mem[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;
   assign busy   = busy_ff;

endmodule

// ===== hdl/hibtb_way_logic.sv =====
// tag match, victim choice and recency update for one set
module hibtb_way_logic (
   input  hibtb_pkg::row_type                   row,
   input  logic [hibtb_pkg::TAG_BITS-1:0]       tag,
   input  logic [hibtb_pkg::ADDR_BITS-1:0]      fall,
   input  logic [hibtb_pkg::ADDR_BITS-1:0]      actual,
   output hibtb_pkg::lookup_type                lookup,
   output hibtb_pkg::row_type                   new_row
);

   always_comb begin
      logic                           found;
      logic                           inv_found;
      logic [hibtb_pkg::WAY_BITS-1:0] hit_way;
      logic [hibtb_pkg::WAY_BITS-1:0] inv_way;
      logic [hibtb_pkg::WAY_BITS-1:0] lru_way;
      logic [hibtb_pkg::WAY_BITS-1:0] sel;
      logic [hibtb_pkg::WAY_BITS-1:0] old_age;

      found     = 1'b0;
      inv_found = 1'b0;
      hit_way   = '0;
      inv_way   = '0;
      lru_way   = '0;

      // first valid way whose tag matches
      for (int w = 0; w < hibtb_pkg::WAYS; w++) begin
         if (!found && row.valid[w] && row.tag[w] == tag) begin
            found   = 1'b1;
            hit_way = hibtb_pkg::WAY_BITS'(w);
         end
      end

      // lowest invalid way, else the oldest rank
      for (int w = 0; w < hibtb_pkg::WAYS; w++) begin
         if (!inv_found && !row.valid[w]) begin
            inv_found = 1'b1;
            inv_way   = hibtb_pkg::WAY_BITS'(w);
         end
      end
      for (int w = 1; w < hibtb_pkg::WAYS; w++) begin
         if (row.age[w] > row.age[lru_way]) begin
            lru_way = hibtb_pkg::WAY_BITS'(w);
         end
      end

      sel     = found ? hit_way : (inv_found ? inv_way : lru_way);
      old_age = row.age[sel];

      new_row = row;
      for (int w = 0; w < hibtb_pkg::WAYS; w++) begin
         if (row.age[w] < old_age) begin
            new_row.age[w] = hibtb_pkg::WAY_BITS'(row.age[w] + 1'b1);
         end
      end
      new_row.age[sel]    = '0;
      new_row.valid[sel]  = 1'b1;
      new_row.tag[sel]    = tag;
      new_row.target[sel] = actual;

      lookup.hit     = found;
      lookup.pred    = found ? row.target[hit_way] : fall;
      lookup.correct = lookup.pred == actual;
   end

endmodule
